/* src/btb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_pkg
// Shared types and constants of the branch target buffer predictor.
// ----------------------------------------------------------------------------
package btb_pkg;

    localparam int BTB_ENTRIES = 32;
    localparam int IDX_W       = 5;
    localparam int MAX_HISTORY = 8;
    localparam int TAG_WIDTH   = 30;
    localparam int CNT_ADDR_W  = IDX_W + MAX_HISTORY;

    localparam logic [2:0] MAX_LOG2    = 3'd5;
    localparam logic [1:0] CNT_RESET   = 2'd1;

    localparam logic [2:0] CFG_ENTRIES_LOG2   = 3'd0;
    localparam logic [2:0] CFG_HISTORY_LENGTH = 3'd1;
    localparam logic [2:0] CFG_TAG_BITS       = 3'd2;
    localparam logic [2:0] CFG_INIT_COUNTER   = 3'd3;
    localparam logic [2:0] CFG_GLOBAL_HISTORY = 3'd4;
    localparam logic [2:0] CFG_GLOBAL_TABLE   = 3'd5;
    localparam logic [2:0] CFG_SHARE_MODE     = 3'd6;

    localparam logic [1:0] SHARE_LSB = 2'd1;
    localparam logic [1:0] SHARE_MID = 2'd2;

    typedef struct packed {
        logic        action;
        logic [31:0] pc;
        logic [31:0] resolved_target;
        logic        resolved_taken;
        logic [31:0] earlier_prediction;
    } in_t;

    typedef struct packed {
        logic        predict_taken;
        logic [31:0] predict_target;
        logic        flushed;
        logic [31:0] branches_seen;
        logic [31:0] flushes_seen;
    } out_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_ALLOC,
        OP_FILL,
        OP_READ,
        OP_EXEC
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [CNT_ADDR_W-1:0] walk;
    } cmd_t;

    typedef struct packed {
        logic alloc;
        logic fill;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

/* src/btb_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_datapath
// Entry arrays, histories, counter memory, statistics and output register.
// ----------------------------------------------------------------------------
module btb_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  btb_pkg::in_t         in_item,
    input  btb_pkg::cmd_t        cmd,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [4:0]      cfg_data,
    input  wire logic            out_ready,
    output btb_pkg::status_t     status,
    output logic                 out_valid,
    output btb_pkg::out_t        out_item
);
    import btb_pkg::*;

    in_t                   item_reg;
    logic [2:0]            el_reg;
    logic [3:0]            hl_reg;
    logic [4:0]            tb_reg;
    logic [1:0]            ic_reg;
    logic                  gh_reg;
    logic                  gt_reg;
    logic [1:0]            sm_reg;
    logic [BTB_ENTRIES-1:0] valid_reg;
    logic [TAG_WIDTH-1:0]  tag_mem [BTB_ENTRIES];
    logic [31:0]           target_mem [BTB_ENTRIES];
    logic [MAX_HISTORY-1:0] lhist_reg [BTB_ENTRIES];
    logic [MAX_HISTORY-1:0] ghist_reg;
    logic [31:0]           branch_reg;
    logic [31:0]           flush_reg;
    logic [1:0]            cnt_mem [1 << CNT_ADDR_W];
    logic [1:0]            rd_data_reg;
    logic                  out_valid_reg;
    out_t                  out_item_reg;

    logic [2:0]            eff;
    logic [IDX_W-1:0]      idx;
    logic [4:0]            tlen;
    logic [31:0]           shifted;
    logic [TAG_WIDTH-1:0]  tag;
    logic                  hit;
    logic [3:0]            hlen;
    logic [MAX_HISTORY-1:0] hmask;
    logic [MAX_HISTORY-1:0] hcur;
    logic [MAX_HISTORY-1:0] hnew;
    logic [MAX_HISTORY-1:0] share_bits;
    logic [MAX_HISTORY-1:0] ci;
    logic [CNT_ADDR_W-1:0] caddr;
    logic [1:0]            newc;
    logic [31:0]           pc4;
    logic                  mispred;
    logic                  mem_we;
    logic [CNT_ADDR_W-1:0] mem_waddr;
    logic [1:0]            mem_wdata;
    logic [31:0]           branch_next;
    logic [31:0]           flush_next;

    always_comb
    begin
        eff     = (el_reg > MAX_LOG2) ? MAX_LOG2 : el_reg;
        idx     = item_reg.pc[IDX_W+1:2] & (5'h1F >> (MAX_LOG2 - eff));
        tlen    = (tb_reg > 5'd30) ? 5'd30 : tb_reg;
        shifted = item_reg.pc >> (6'd2 + {3'b000, eff});
        tag     = shifted[TAG_WIDTH-1:0] & ({TAG_WIDTH{1'b1}} >> (5'd30 - tlen));
        hit     = valid_reg[idx] && (tag_mem[idx] == tag);
        if (hl_reg == 4'd0)
            hlen = 4'd1;
        else if (hl_reg > 4'd8)
            hlen = 4'd8;
        else
            hlen = hl_reg;
        hmask = 8'hFF >> (4'd8 - hlen);
        hcur  = gh_reg ? ghist_reg : lhist_reg[idx];
        hnew  = {hcur[MAX_HISTORY-2:0], item_reg.resolved_taken} & hmask;
        case (sm_reg)
            SHARE_LSB: share_bits = item_reg.pc[9:2] & hmask;
            SHARE_MID: share_bits = item_reg.pc[23:16] & hmask;
            default:   share_bits = '0;
        endcase
        ci    = (hcur & hmask) ^ share_bits;
        caddr = {(gt_reg ? {IDX_W{1'b0}} : idx), ci};
        if (item_reg.resolved_taken)
            newc = (rd_data_reg == 2'd3) ? 2'd3 : rd_data_reg + 2'd1;
        else
            newc = (rd_data_reg == 2'd0) ? 2'd0 : rd_data_reg - 2'd1;
        pc4     = item_reg.pc + 32'd4;
        mispred = item_reg.resolved_taken ?
                  (item_reg.earlier_prediction != item_reg.resolved_target) :
                  (item_reg.earlier_prediction != pc4);
        branch_next = branch_reg + 32'd1;
        flush_next  = flush_reg + {31'd0, mispred};
        mem_we    = 1'b0;
        mem_waddr = caddr;
        mem_wdata = newc;
        case (cmd.op)
            OP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cmd.walk;
                mem_wdata = CNT_RESET;
            end
            OP_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = {idx, cmd.walk[MAX_HISTORY-1:0]};
                mem_wdata = ic_reg;
            end
            OP_EXEC:
            begin
                mem_we = item_reg.action;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign status.alloc    = item_reg.action && !hit;
    assign status.fill     = !gt_reg;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cnt_mem[mem_waddr] <= mem_wdata;
        if (cmd.op == OP_READ)
            rd_data_reg <= cnt_mem[caddr];
        if (cmd.op == OP_CAPTURE)
            item_reg <= in_item;
        if (cmd.op == OP_ALLOC)
        begin
            tag_mem[idx]    <= tag;
            target_mem[idx] <= item_reg.resolved_target;
        end
        if (cmd.op == OP_EXEC && item_reg.action)
            target_mem[idx] <= item_reg.resolved_target;
        if (cmd.op == OP_EXEC)
        begin
            if (item_reg.action)
            begin
                out_item_reg.predict_taken  <= 1'b0;
                out_item_reg.predict_target <= '0;
                out_item_reg.flushed        <= mispred;
                out_item_reg.branches_seen  <= branch_next;
                out_item_reg.flushes_seen   <= flush_next;
            end
            else
            begin
                out_item_reg.predict_taken  <= hit && rd_data_reg[1];
                out_item_reg.predict_target <= (hit && rd_data_reg[1]) ?
                                               target_mem[idx] : pc4;
                out_item_reg.flushed        <= 1'b0;
                out_item_reg.branches_seen  <= branch_reg;
                out_item_reg.flushes_seen   <= flush_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            el_reg        <= 3'd5;
            hl_reg        <= 4'd8;
            tb_reg        <= 5'd30;
            ic_reg        <= CNT_RESET;
            gh_reg        <= 1'b0;
            gt_reg        <= 1'b0;
            sm_reg        <= 2'd0;
            valid_reg     <= '0;
            ghist_reg     <= '0;
            branch_reg    <= '0;
            flush_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BTB_ENTRIES; i++)
                lhist_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENTRIES_LOG2:   el_reg <= cfg_data[2:0];
                    CFG_HISTORY_LENGTH: hl_reg <= cfg_data[3:0];
                    CFG_TAG_BITS:       tb_reg <= cfg_data;
                    CFG_INIT_COUNTER:   ic_reg <= cfg_data[1:0];
                    CFG_GLOBAL_HISTORY: gh_reg <= cfg_data[0];
                    CFG_GLOBAL_TABLE:   gt_reg <= cfg_data[0];
                    CFG_SHARE_MODE:     sm_reg <= cfg_data[1:0];
                    default:            el_reg <= el_reg;
                endcase
            end
            if (cmd.op == OP_ALLOC)
            begin
                valid_reg[idx] <= 1'b1;
                if (!gh_reg)
                    lhist_reg[idx] <= '0;
            end
            if (cmd.op == OP_EXEC && item_reg.action)
            begin
                branch_reg <= branch_next;
                flush_reg  <= flush_next;
                if (gh_reg)
                    ghist_reg <= hnew;
                else
                    lhist_reg[idx] <= hnew;
            end
            if (cmd.op == OP_EXEC)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

/* src/btb_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_controller
// Sequencer: counter clearing pass, lookup, allocation row fill, counter read, execute.
// ----------------------------------------------------------------------------
module btb_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  btb_pkg::status_t   status,
    output btb_pkg::cmd_t      cmd
);
    import btb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_FILL,
        S_READ,
        S_EXEC
    } state_t;

    state_t                state_reg;
    logic [CNT_ADDR_W-1:0] walk_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign cmd.walk = walk_reg;

    always_comb
    begin
        case (state_reg)
            S_CLEAR: cmd.op = OP_CLEAR;
            S_IDLE:  cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
            S_LOOK:  cmd.op = status.alloc ? OP_ALLOC : OP_NONE;
            S_FILL:  cmd.op = OP_FILL;
            S_READ:  cmd.op = OP_READ;
            S_EXEC:  cmd.op = status.out_busy ? OP_NONE : OP_EXEC;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            walk_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    walk_reg <= walk_reg + 1'b1;
                    if (&walk_reg)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_LOOK;
                end
                S_LOOK:
                begin
                    if (status.alloc && status.fill)
                        state_reg <= S_FILL;
                    else
                        state_reg <= S_READ;
                end
                S_FILL:
                begin
                    if (&walk_reg[MAX_HISTORY-1:0])
                    begin
                        walk_reg  <= '0;
                        state_reg <= S_READ;
                    end
                    else
                        walk_reg <= walk_reg + 1'b1;
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (!status.out_busy)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LOOK))
        else $error("accepted item did not start lookup");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && status.out_busy) |=> (state_reg == S_EXEC))
        else $error("execute left while output stalled");
    a_fill_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && (&walk_reg[MAX_HISTORY-1:0])) |=>
        (state_reg == S_READ && walk_reg == '0))
        else $error("row fill did not end in read");
`endif

endmodule
`default_nettype wire

/* src/btb_two_level_branch_predictor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped BTB with two-level two-bit counter direction prediction.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one predict or update item; the
// output channel out_valid/out_ready returns exactly one result per item.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// An accepted item passes lookup, counter memory read and execute, and
// the result is held in the output register. An update that misses with
// per-entry counter rows first refills the row, one counter memory write
// per cycle. Items are taken one at a time: in_ready is high only in idle.
// Reset: after rst_n rises, the counter memory is swept once, during
// which in_ready stays low; configuration writes are taken.
// Stall: the result waits in the output register; a held result blocks
// only the execute step of the following item.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  btb_pkg::in_t     in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output btb_pkg::out_t    out_item,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);
    import btb_pkg::*;

    cmd_t    cmd;
    status_t status;

    btb_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    btb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

/* test/btb_two_level_branch_predictor_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_tb
// Drives predict and update items through the BTB predictor under several
// register settings and idling patterns, predicts every result with a
// behavioral copy of the buffer, and compares each whole result with it.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_tb;

    import btb_pkg::*;

    localparam int ROW        = 256;
    localparam int WATCH_MAX  = 50000;
    localparam int SETTLE_CYC = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_item;
    logic        out_valid;
    logic        out_ready;
    out_t        out_item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [4:0]  cfg_data;

    // predictor state
    logic [2:0]  m_log2;
    logic [3:0]  m_hlen;
    logic [4:0]  m_tbits;
    logic [1:0]  m_init;
    logic        m_ghist;
    logic        m_gtab;
    logic [1:0]  m_share;
    logic        m_valid [BTB_ENTRIES];
    logic [31:0] m_tag [BTB_ENTRIES];
    logic [31:0] m_target [BTB_ENTRIES];
    logic [7:0]  m_lhist [BTB_ENTRIES];
    logic [7:0]  m_shist;
    logic [1:0]  m_cnt [BTB_ENTRIES * ROW];
    logic [31:0] m_branches;
    logic [31:0] m_flushes;

    out_t        expected_results[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    btb_two_level_branch_predictor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned eff_log2();
        return (m_log2 > MAX_LOG2) ? int'(MAX_LOG2) : int'(m_log2);
    endfunction

    function automatic logic [31:0] hist_mask();
        int unsigned len;
        len = m_hlen;
        if (len < 1) len = 1;
        if (len > MAX_HISTORY) len = MAX_HISTORY;
        return (32'd1 << len) - 32'd1;
    endfunction

    function automatic int unsigned counter_addr(logic [31:0] pc, int unsigned idx);
        logic [31:0] m;
        logic [31:0] ci;
        m  = hist_mask();
        ci = (m_ghist ? {24'd0, m_shist} : {24'd0, m_lhist[idx]}) & m;
        if (m_share == SHARE_LSB)
            ci = ci ^ ((pc >> 2) & m);
        else if (m_share == SHARE_MID)
            ci = ci ^ ((pc >> 16) & m);
        return (m_gtab ? 0 : idx) * ROW + int'(ci[7:0]);
    endfunction

    function automatic out_t branch_outcome(in_t it);
        out_t        r;
        int unsigned idx;
        int unsigned t;
        int unsigned a;
        logic [31:0] tag;
        logic [31:0] tmask;
        logic        hit;
        logic [7:0]  h;
        r     = '0;
        idx   = (it.pc >> 2) & ((32'd1 << eff_log2()) - 1);
        t     = (m_tbits > TAG_WIDTH) ? TAG_WIDTH : m_tbits;
        tmask = (32'd1 << t) - 32'd1;
        tag   = (it.pc >> (2 + eff_log2())) & tmask;
        hit   = m_valid[idx] && m_tag[idx] == tag;
        if (!it.action)
        begin
            r.predict_target = it.pc + 32'd4;
            if (hit && m_cnt[counter_addr(it.pc, idx)] >= 2'd2)
            begin
                r.predict_taken  = 1'b1;
                r.predict_target = m_target[idx];
            end
        end
        else
        begin
            m_branches++;
            if (!hit)
            begin
                m_valid[idx] = 1'b1;
                m_tag[idx]   = tag;
                if (!m_ghist) m_lhist[idx] = '0;
                if (!m_gtab)
                    for (int k = 0; k < ROW; k++) m_cnt[idx * ROW + k] = m_init;
            end
            if ((it.resolved_taken && it.earlier_prediction != it.resolved_target) ||
                (!it.resolved_taken && it.earlier_prediction != it.pc + 32'd4))
            begin
                r.flushed = 1'b1;
                m_flushes++;
            end
            m_target[idx] = it.resolved_target;
            a = counter_addr(it.pc, idx);
            if (it.resolved_taken && m_cnt[a] != 2'd3) m_cnt[a]++;
            if (!it.resolved_taken && m_cnt[a] != 2'd0) m_cnt[a]--;
            h = m_ghist ? m_shist : m_lhist[idx];
            h = ((h << 1) | it.resolved_taken) & hist_mask();
            if (m_ghist) m_shist = h;
            else m_lhist[idx] = h;
        end
        r.branches_seen = m_branches;
        r.flushes_seen  = m_flushes;
        return r;
    endfunction

    task automatic send_item(in_t it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(branch_outcome(it));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [4:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            CFG_ENTRIES_LOG2:   m_log2  = value[2:0];
            CFG_HISTORY_LENGTH: m_hlen  = value[3:0];
            CFG_TAG_BITS:       m_tbits = value;
            CFG_INIT_COUNTER:   m_init  = value[1:0];
            CFG_GLOBAL_HISTORY: m_ghist = value[0];
            CFG_GLOBAL_TABLE:   m_gtab  = value[0];
            CFG_SHARE_MODE:     m_share = value[1:0];
            default: ;
        endcase
    endtask

    task automatic configure(int lg, int hl, int tb, int ic, int gh, int gt, int sm);
        drain();
        write_reg(CFG_ENTRIES_LOG2, 5'(lg));
        write_reg(CFG_HISTORY_LENGTH, 5'(hl));
        write_reg(CFG_TAG_BITS, 5'(tb));
        write_reg(CFG_INIT_COUNTER, 5'(ic));
        write_reg(CFG_GLOBAL_HISTORY, 5'(gh));
        write_reg(CFG_GLOBAL_TABLE, 5'(gt));
        write_reg(CFG_SHARE_MODE, 5'(sm));
    endtask

    function automatic in_t make_item(logic act, logic [31:0] pc, logic tk, int wrong);
        in_t it;
        it.action             = act;
        it.pc                 = pc;
        it.resolved_target    = $urandom();
        it.resolved_taken     = tk;
        it.earlier_prediction = tk ? it.resolved_target : pc + 32'd4;
        if (wrong != 0) it.earlier_prediction = $urandom();
        return it;
    endfunction

    task automatic test_directed();
        in_t it;
        send_item(make_item(1'b0, 32'h0000_0000, 1'b0, 0));
        send_item(make_item(1'b0, 32'hFFFF_FFFF, 1'b1, 0));
        send_item(make_item(1'b1, 32'h0000_0000, 1'b1, 0));
        send_item(make_item(1'b1, 32'h0000_0000, 1'b1, 1));
        send_item(make_item(1'b0, 32'h0000_0000, 1'b0, 0));
        send_item(make_item(1'b1, 32'hFFFF_FFFF, 1'b0, 0));
        send_item(make_item(1'b1, 32'hFFFF_FFFF, 1'b0, 1));
        send_item(make_item(1'b0, 32'hFFFF_FFFF, 1'b0, 0));
        it = '1;
        send_item(it);
        it = '0;
        it.action = 1'b1;
        send_item(it);
        // tag conflict on the same entry
        send_item(make_item(1'b1, 32'h8000_0000, 1'b1, 0));
        send_item(make_item(1'b0, 32'h0000_0000, 1'b0, 0));
        send_item(make_item(1'b0, 32'h8000_0000, 1'b0, 0));
        send_item(make_item(1'b1, 32'h0001_0004, 1'b1, 0));
        send_item(make_item(1'b1, 32'h0001_0004, 1'b1, 0));
        send_item(make_item(1'b0, 32'h0001_0004, 1'b0, 0));
    endtask

    // training streams on few pcs, with some noise
    task automatic test_random(int count, int npcs);
        logic [31:0] pcs [8];
        logic [31:0] tgts [8];
        int          k;
        in_t         it;
        for (int i = 0; i < 8; i++)
        begin
            pcs[i]  = $urandom();
            tgts[i] = $urandom();
        end
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(npcs - 1);
            if ($urandom_range(9) == 0)
                it = make_item(1'($urandom()), $urandom(), 1'($urandom()), $urandom_range(1));
            else
            begin
                it = make_item(1'($urandom_range(1)), pcs[k], 1'($urandom_range(3) != 0),
                               $urandom_range(5) == 0);
                if ($urandom_range(3) != 0)
                begin
                    it.resolved_target = tgts[k];
                    if (it.resolved_taken && it.earlier_prediction != it.resolved_target
                        && $urandom_range(1) == 0)
                        it.earlier_prediction = tgts[k];
                end
            end
            send_item(it);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b1;
        else
            out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: %p", $time, out_item);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item !== want)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX)
        begin
            $display("btb_two_level_branch_predictor verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        m_log2 = 3'd5; m_hlen = 4'd8; m_tbits = 5'd30; m_init = 2'd1;
        m_ghist = 1'b0; m_gtab = 1'b0; m_share = 2'd0;
        m_shist = '0; m_branches = '0; m_flushes = '0;
        for (int i = 0; i < BTB_ENTRIES; i++)
        begin
            m_valid[i] = 1'b0; m_tag[i] = '0; m_target[i] = '0; m_lhist[i] = '0;
        end
        for (int i = 0; i < BTB_ENTRIES * ROW; i++) m_cnt[i] = 2'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(150, 8);
        configure(0, 1, 0, 3, 1, 1, 1);
        test_directed();
        test_random(150, 4);
        send_idle_pct = 65;
        configure(7, 15, 31, 0, 0, 0, 2);
        test_random(200, 8);
        configure(3, 0, 4, 2, 1, 0, 3);
        test_random(200, 8);
        send_idle_pct  = 0;
        recv_stall_pct = 65;
        configure(2, 4, 12, 1, 0, 1, 1);
        test_random(200, 6);
        configure(5, 8, 30, 3, 0, 0, 0);
        test_random(200, 8);
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        configure(1, 3, 16, 2, 1, 1, 2);
        test_random(200, 5);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(4, 6, 20, 0, 0, 1, 0);
        test_random(200, 8);
        drain();

        if (errors == 0)
            $display("btb_two_level_branch_predictor verification clean");
        else
            $display("btb_two_level_branch_predictor verification failed");
        $finish;
    end

endmodule
`default_nettype wire
